// ===== rtl/rhsv_pkg.sv =====
// Package for the 8-bit RGB to HSV converter.
// Holds the scaling constants, sector bases and the beat types that the
// pipeline and its divider share. No dependencies.
package rhsv_pkg;

    localparam int DivStages = 8;
    localparam int QuotWidth = 8;
    localparam int NumWidth  = 16;

    localparam logic [7:0] BaseRed   = 8'd0;
    localparam logic [7:0] BaseGreen = 8'd85;
    localparam logic [7:0] BaseBlue  = 8'd171;
    localparam logic [5:0] HueScale  = 6'd43;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] base;
        logic       neg;
        logic       zero;
    } rhsv_side_t;

    typedef struct packed {
        logic [NumWidth-1:0]  sat_rem;
        logic [7:0]           sat_div;
        logic [QuotWidth-1:0] sat_q;
        logic [NumWidth-1:0]  hue_rem;
        logic [7:0]           hue_div;
        logic [QuotWidth-1:0] hue_q;
        rhsv_side_t           side;
    } rhsv_div_t;

endpackage

// ===== rtl/rhsv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes:
// saturation and hue magnitude. Sideband travels with each beat.
// Depends on rhsv_pkg.
module rhsv_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rhsv_pkg::rhsv_div_t in_beat,
    output logic              out_valid,
    input  logic              out_stall,
    output rhsv_pkg::rhsv_div_t out_beat
);

    rhsv_pkg::rhsv_div_t                stage_reg [rhsv_pkg::DivStages];
    logic [rhsv_pkg::DivStages-1:0]     valid_reg;
    logic [rhsv_pkg::DivStages:0]       ready;

    assign ready[rhsv_pkg::DivStages] = !out_stall;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[rhsv_pkg::DivStages-1];
    assign out_beat  = stage_reg[rhsv_pkg::DivStages-1];

    for (genvar k = 0; k < rhsv_pkg::DivStages; k++) begin : g_stage
        localparam int Sh = rhsv_pkg::DivStages - 1 - k;

        rhsv_pkg::rhsv_div_t src;
        rhsv_pkg::rhsv_div_t stage_next;
        logic                src_valid;
        logic [rhsv_pkg::NumWidth:0] sat_trial;
        logic [rhsv_pkg::NumWidth:0] hue_trial;

        if (k == 0) begin : g_first
            assign src       = in_beat;
            assign src_valid = in_valid;
        end
        else begin : g_rest
            assign src       = stage_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        assign ready[k] = !valid_reg[k] || ready[k+1];

        always_comb
        begin
            stage_next = src;
            sat_trial  = {1'b0, src.sat_rem}
                       - ({{(rhsv_pkg::NumWidth-7){1'b0}}, src.sat_div} << Sh);
            hue_trial  = {1'b0, src.hue_rem}
                       - ({{(rhsv_pkg::NumWidth-7){1'b0}}, src.hue_div} << Sh);
            if (!sat_trial[rhsv_pkg::NumWidth])
            begin
                stage_next.sat_rem   = sat_trial[rhsv_pkg::NumWidth-1:0];
                stage_next.sat_q[Sh] = 1'b1;
            end
            if (!hue_trial[rhsv_pkg::NumWidth])
            begin
                stage_next.hue_rem   = hue_trial[rhsv_pkg::NumWidth-1:0];
                stage_next.hue_q[Sh] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ready[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[k] && src_valid)
            begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    // remainder below divisor once all bits are resolved
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.side.zero
        |-> out_beat.sat_rem < {8'd0, out_beat.sat_div})
        else $error("saturation remainder not reduced");

    a_hue_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.side.zero
        |-> out_beat.hue_q <= {2'b00, rhsv_pkg::HueScale})
        else $error("hue magnitude above one sector");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted beat lost at first stage");

endmodule

// ===== rtl/rgb_to_hsv_8bit.sv =====
// Usage
// -----
// Converts a stream of 8-bit RGB pixels to 8-bit hue, saturation and
// brightness (value). Input channel: in_valid / in_stall with red, green,
// blue. Output channel: out_valid / out_stall with hue, saturation,
// brightness. A beat moves at a clock edge where valid is high and stall low.
// Pipeline stages in order: sector/min/max, numerator products,
// eight divider stages (one quotient bit each, saturation and hue in
// parallel) and the output register. Throughput is one pixel per clock while out_stall is low.
// Every stage keeps its own valid bit, so bubbles are squeezed out while the
// receiver stalls; in_stall rises only when every stage holds a beat.
// A stalled output beat holds steady. Reset (rst_n low, asynchronous) empties
// all stages; the block keeps no other state and needs no setup.
// Depends on rhsv_pkg and rhsv_div.
module rgb_to_hsv_8bit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] brightness
);

    // stage 1: max, min, sector
    logic                 s1_valid_reg;
    rhsv_pkg::rhsv_side_t s1_side_reg;
    rhsv_pkg::rhsv_side_t s1_side_next;
    logic [7:0]           s1_delta_reg;
    logic [7:0]           s1_delta_next;
    logic [7:0]           s1_diff_reg;
    logic [7:0]           s1_diff_next;
    logic                 s1_ready;

    // stage 2: numerators
    logic                 s2_valid_reg;
    rhsv_pkg::rhsv_div_t  s2_beat_reg;
    rhsv_pkg::rhsv_div_t  s2_beat_next;
    logic                 s2_ready;
    logic [13:0]          hue_prod;

    // divider
    logic                 div_in_stall;
    logic                 div_out_valid;
    logic                 div_out_stall;
    rhsv_pkg::rhsv_div_t  div_out_beat;

    // output
    logic                 out_valid_reg;
    logic [7:0]           hue_reg;
    logic [7:0]           hue_next;
    logic [7:0]           sat_reg;
    logic [7:0]           sat_next;
    logic [7:0]           bright_reg;
    logic                 out_ready;

    logic [7:0]           mx;
    logic [7:0]           mn;
    logic [7:0]           p;
    logic [7:0]           q;

    assign out_ready     = !out_valid_reg || !out_stall;
    assign div_out_stall = !out_ready;
    assign s2_ready      = !s2_valid_reg || !div_in_stall;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign in_stall      = !s1_ready;

    always_comb
    begin
        s1_side_next = '0;
        if (red >= green && red >= blue)
        begin
            mx                = red;
            s1_side_next.base = rhsv_pkg::BaseRed;
            p                 = green;
            q                 = blue;
        end
        else if (green >= blue)
        begin
            mx                = green;
            s1_side_next.base = rhsv_pkg::BaseGreen;
            p                 = blue;
            q                 = red;
        end
        else
        begin
            mx                = blue;
            s1_side_next.base = rhsv_pkg::BaseBlue;
            p                 = red;
            q                 = green;
        end
        mn = (red < green) ? red : green;
        if (blue < mn)
        begin
            mn = blue;
        end
        s1_delta_next           = mx - mn;
        s1_side_next.brightness = mx;
        s1_side_next.zero       = (s1_delta_next == 8'd0);
        s1_side_next.neg        = (p < q);
        s1_diff_next            = (p < q) ? (q - p) : (p - q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_side_reg  <= s1_side_next;
            s1_delta_reg <= s1_delta_next;
            s1_diff_reg  <= s1_diff_next;
        end
    end

    assign hue_prod = {6'd0, s1_diff_reg} * {8'd0, rhsv_pkg::HueScale};

    always_comb
    begin
        s2_beat_next         = '0;
        s2_beat_next.sat_rem = {s1_delta_reg, 8'd0} - {8'd0, s1_delta_reg};
        s2_beat_next.sat_div = s1_side_reg.brightness;
        s2_beat_next.hue_rem = {2'd0, hue_prod};
        s2_beat_next.hue_div = s1_delta_reg;
        s2_beat_next.side    = s1_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_beat_reg <= s2_beat_next;
        end
    end

    rhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_stall  (div_in_stall),
        .in_beat   (s2_beat_reg),
        .out_valid (div_out_valid),
        .out_stall (div_out_stall),
        .out_beat  (div_out_beat)
    );

    always_comb
    begin
        if (div_out_beat.side.zero)
        begin
            hue_next = 8'd0;
            sat_next = 8'd0;
        end
        else
        begin
            sat_next = div_out_beat.sat_q;
            hue_next = div_out_beat.side.neg
                     ? (div_out_beat.side.base - div_out_beat.hue_q)
                     : (div_out_beat.side.base + div_out_beat.hue_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && div_out_valid)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= div_out_beat.side.brightness;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && brightness == 8'd0 |-> saturation == 8'd0 && hue == 8'd0)
        else $error("black pixel with nonzero hue or saturation");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == 8'd0 |-> hue == 8'd0)
        else $error("grey pixel with nonzero hue");

    a_diff: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_diff_reg <= s1_delta_reg)
        else $error("channel difference exceeds range");

endmodule
